// File: src/plceb_pkg.sv
// shared types, constants and register codes for the pixel luma/color/edge boxer
`default_nettype none
package plceb_pkg;

    localparam int COORD_BITS = 10;
    localparam int COUNT_BITS = 17;
    localparam int PIX_BITS   = 8;
    localparam int SEL_BITS   = 3;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRODUCT_SELECT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_THRESHOLD = 2'd1;

    localparam logic [SEL_BITS-1:0] SEL_RESET       = 3'd0;
    localparam logic [PIX_BITS-1:0] THRESHOLD_RESET = 8'd5;

    // product codes
    localparam logic [SEL_BITS-1:0] PROD_ONE   = 3'd1;
    localparam logic [SEL_BITS-1:0] PROD_TWO   = 3'd2;
    localparam logic [SEL_BITS-1:0] PROD_THREE = 3'd3;
    localparam logic [SEL_BITS-1:0] PROD_FOUR  = 3'd4;
    localparam logic [SEL_BITS-1:0] PROD_FIVE  = 3'd5;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [PIX_BITS-1:0]   t_pix;

    typedef struct packed {
        t_pix   red;
        t_pix   green;
        t_pix   blue;
        t_coord col;
        t_coord row;
        logic   last_pixel;
    } t_in_item;

    typedef struct packed {
        t_coord left;
        t_coord right;
        t_coord top;
        t_coord bottom;
    } t_box;

    typedef struct packed {
        t_pix   gray;
        logic   frame_done;
        t_coord edge_left;
        t_coord edge_right;
        t_coord edge_top;
        t_coord edge_bottom;
        t_coord color_left;
        t_coord color_right;
        t_coord color_top;
        t_coord color_bottom;
        t_count edge_count;
        t_count color_count;
    } t_out_item;

endpackage
`default_nettype wire

// File: src/pixel_luma_color_edge_boxer_unit.sv
// top level: pixel luma, color hit box and horizontal edge box per frame
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  in      | input     | valid / stall      | t_in_item (rgb, col, row, last)
//  out     | output    | valid / stall      | t_out_item (gray, boxes, counts)
//  cfg     | input     | valid / ready      | 2-bit index, 8-bit data
//
// one item per cycle sustained while the output does not stall; each result
// passes the input register, then the luma/compare/box logic and the result register
// synchronous active-low reset clears config, valids and all frame state
// an output stall holds the result; the input register keeps taking items
// until it also holds one, then the input side stalls
`default_nettype none
module pixel_luma_color_edge_boxer_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire plceb_pkg::t_in_item            i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output plceb_pkg::t_out_item                o_out_data,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [plceb_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire [7:0]                           i_cfg_data
);
    import plceb_pkg::*;

    logic [SEL_BITS-1:0] r_sel;
    t_pix                r_threshold;

    logic     r_in_valid;
    t_in_item r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    t_pix   r_prev_luma;
    logic   r_prev_valid;

    logic   advance;
    t_pix   gray;
    t_pix   diff;
    t_coord left_col;
    logic   color_hit;
    logic   edge_hit;
    t_box   color_box;
    t_box   edge_box;
    t_count color_count;
    t_count edge_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= SEL_RESET;
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PRODUCT_SELECT: r_sel       <= i_cfg_data[SEL_BITS-1:0];
                CFG_EDGE_THRESHOLD: r_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    plceb_luma u_luma (
        .i_red   (r_in.red),
        .i_green (r_in.green),
        .i_blue  (r_in.blue),
        .o_gray  (gray)
    );

    plceb_color_match u_color (
        .i_sel   (r_sel),
        .i_red   (r_in.red),
        .i_green (r_in.green),
        .i_blue  (r_in.blue),
        .i_col   (r_in.col),
        .i_row   (r_in.row),
        .o_hit   (color_hit)
    );

    // edge point sits at the left neighbour, inside the inspection window
    assign left_col = r_in.col - 1'b1;
    assign diff     = (gray > r_prev_luma) ? (gray - r_prev_luma) : (r_prev_luma - gray);
    assign edge_hit = r_prev_valid && (r_in.col != '0) && (diff > r_threshold)
                   && (left_col inside {[200:469]}) && (r_in.row inside {[50:459]});

    plceb_box_accum u_color_box (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_hit     (color_hit),
        .i_x       (r_in.col),
        .i_y       (r_in.row),
        .i_clear   (r_in.last_pixel),
        .o_box     (color_box),
        .o_count   (color_count)
    );

    plceb_box_accum u_edge_box (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_hit     (edge_hit),
        .i_x       (left_col),
        .i_y       (r_in.row),
        .i_clear   (r_in.last_pixel),
        .o_box     (edge_box),
        .o_count   (edge_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_luma  <= '0;
            r_prev_valid <= 1'b0;
        end else if (advance) begin
            if (r_in.last_pixel) begin
                r_prev_luma  <= '0;
                r_prev_valid <= 1'b0;
            end else begin
                r_prev_luma  <= gray;
                r_prev_valid <= 1'b1;
            end
        end
    end

    always_comb begin
        n_out      = '0;
        n_out.gray = gray;
        if (r_in.last_pixel) begin
            n_out.frame_done   = 1'b1;
            n_out.edge_left    = edge_box.left;
            n_out.edge_right   = edge_box.right;
            n_out.edge_top     = edge_box.top;
            n_out.edge_bottom  = edge_box.bottom;
            n_out.color_left   = color_box.left;
            n_out.color_right  = color_box.right;
            n_out.color_top    = color_box.top;
            n_out.color_bottom = color_box.bottom;
            n_out.edge_count   = edge_count;
            n_out.color_count  = color_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// File: src/plceb_luma.sv
// bt.601 luma in q16 fixed point, truncated
`default_nettype none
module plceb_luma (
    input  wire plceb_pkg::t_pix i_red,
    input  wire plceb_pkg::t_pix i_green,
    input  wire plceb_pkg::t_pix i_blue,
    output plceb_pkg::t_pix      o_gray
);
    import plceb_pkg::*;

    localparam logic [23:0] K_RED   = 24'd19595;
    localparam logic [23:0] K_GREEN = 24'd38470;
    localparam logic [23:0] K_BLUE  = 24'd7471;

    logic [23:0] sum;

    // max sum is 65536*255, fits in 24 bits
    assign sum = ({16'd0, i_red} * K_RED) + ({16'd0, i_green} * K_GREEN)
               + ({16'd0, i_blue} * K_BLUE);
    assign o_gray = sum[23:16];

endmodule
`default_nettype wire

// File: src/plceb_color_match.sv
// per-product window and color band test
`default_nettype none
module plceb_color_match (
    input  wire [plceb_pkg::SEL_BITS-1:0] i_sel,
    input  wire plceb_pkg::t_pix          i_red,
    input  wire plceb_pkg::t_pix          i_green,
    input  wire plceb_pkg::t_pix          i_blue,
    input  wire plceb_pkg::t_coord        i_col,
    input  wire plceb_pkg::t_coord        i_row,
    output logic                          o_hit
);
    import plceb_pkg::*;

    logic band3_a;
    logic band3_b;

    assign band3_a = (i_red inside {[100:124]}) && (i_green inside {[41:89]})
                  && (i_blue inside {[11:99]});
    assign band3_b = (i_red inside {[70:99]}) && (i_green inside {[11:49]})
                  && (i_blue < 8'd10);

    always_comb begin
        case (i_sel)
            PROD_ONE: begin
                o_hit = (i_row inside {[301:449]}) && (i_col inside {[201:469]})
                     && (i_red inside {[71:174]}) && (i_green < 8'd100)
                     && (i_blue < 8'd50);
            end
            PROD_TWO: begin
                o_hit = (i_row inside {[71:179]}) && (i_col inside {[201:469]})
                     && (i_red == 8'd0) && (i_blue == 8'd0) && (i_green > 8'd90);
            end
            PROD_THREE: begin
                o_hit = (i_row inside {[71:219]}) && (i_col inside {[201:469]})
                     && (band3_a || band3_b);
            end
            PROD_FOUR: begin
                o_hit = (i_row inside {[71:199]}) && (i_col inside {[201:469]})
                     && (i_red == 8'd0) && (i_green == 8'd0) && (i_blue == 8'd0);
            end
            PROD_FIVE: begin
                o_hit = (i_row inside {[361:449]}) && (i_col inside {[251:419]})
                     && (i_red < 8'd100) && (i_green < 8'd100) && (i_blue > 8'd150);
            end
            default: begin
                o_hit = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/plceb_box_accum.sv
// bounding box and saturating hit count for one set of points
`default_nettype none
module plceb_box_accum (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_advance,
    input  wire                     i_hit,
    input  wire plceb_pkg::t_coord  i_x,
    input  wire plceb_pkg::t_coord  i_y,
    input  wire                     i_clear,
    output plceb_pkg::t_box         o_box,
    output plceb_pkg::t_count       o_count
);
    import plceb_pkg::*;

    t_box   r_box;
    t_box   n_box;
    t_count r_count;
    t_count n_count;

    always_comb begin
        n_box   = r_box;
        n_count = r_count;
        if (i_hit) begin
            if (r_count == '0) begin
                n_box.left   = i_x;
                n_box.right  = i_x;
                n_box.top    = i_y;
                n_box.bottom = i_y;
            end else begin
                if (i_x < r_box.left)   n_box.left   = i_x;
                if (i_x > r_box.right)  n_box.right  = i_x;
                if (i_y < r_box.top)    n_box.top    = i_y;
                if (i_y > r_box.bottom) n_box.bottom = i_y;
            end
            if (r_count != COUNT_MAX) n_count = r_count + 1'b1;
        end
    end

    // the updated box is what a frame's last item reports
    assign o_box   = n_box;
    assign o_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box   <= '0;
            r_count <= '0;
        end else if (i_advance) begin
            if (i_clear) begin
                r_box   <= '0;
                r_count <= '0;
            end else begin
                r_box   <= n_box;
                r_count <= n_count;
            end
        end
    end

endmodule
`default_nettype wire

// File: tb/sv/tb_pixel_luma_color_edge_boxer_unit.sv
`timescale 1ns / 1ps
// self-checking testbench for the pixel luma, color box and edge box unit
module tb_pixel_luma_color_edge_boxer_unit;
    import plceb_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [SEL_BITS-1:0]     SEL_SPARE_7 = 3'd7;

    localparam t_coord EDGE_COL_LO = 10'd200;
    localparam t_coord EDGE_COL_HI = 10'd469;
    localparam t_coord EDGE_ROW_LO = 10'd50;
    localparam t_coord EDGE_ROW_HI = 10'd459;

    localparam int HOLD_CYCLES = 120;
    localparam int PHASE_ITEMS = 135;

    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    t_in_item                i_in_data   = '0;
    logic                    i_out_stall = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [7:0]              i_cfg_data  = '0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic                    o_cfg_ready;
    t_out_item               o_out_data;

    // predictor copy of config and frame state
    logic [SEL_BITS-1:0] sel_reg      = SEL_RESET;
    t_pix                thr_reg      = THRESHOLD_RESET;
    t_pix                last_luma    = '0;
    logic                last_luma_ok = 1'b0;
    t_box                edge_bbox    = '0;
    t_box                color_bbox   = '0;
    t_count              edge_hits    = '0;
    t_count              color_hits   = '0;

    t_in_item  pending_px[$];
    t_out_item due_results[$];

    int n_queued   = 0;
    int n_accepted = 0;
    int cfg_seen   = 0;
    int n_bad      = 0;
    int gap_left   = 0;
    int stall_left = 0;
    bit px_taken   = 1'b0;
    bit idle_on    = 1'b1;
    bit rx_hold    = 1'b0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    pixel_luma_color_edge_boxer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic logic color_match(input logic [SEL_BITS-1:0] sel, input t_in_item px);
        t_pix   r, g, b;
        t_coord i, j;
        r = px.red;
        g = px.green;
        b = px.blue;
        i = px.col;
        j = px.row;
        case (sel)
            PROD_ONE: return j > 300 && j < 450 && i > 200 && i < 470 &&
                             r > 70 && r < 175 && g < 100 && b < 50;
            PROD_TWO: return j > 70 && j < 180 && i > 200 && i < 470 &&
                             r == 0 && b == 0 && g > 90;
            PROD_THREE: return j > 70 && j < 220 && i > 200 && i < 470 &&
                             ((r >= 100 && r < 125 && g > 40 && g < 90 && b > 10 && b < 100) ||
                              (r >= 70 && r < 100 && g > 10 && g < 50 && b < 10));
            PROD_FOUR: return j > 70 && j < 200 && i > 200 && i < 470 &&
                             r == 0 && g == 0 && b == 0;
            PROD_FIVE: return j > 360 && j < 450 && i > 250 && i < 420 &&
                             r < 100 && g < 100 && b > 150;
            default: return 1'b0;
        endcase
    endfunction

    // the first point of a set opens the box on itself
    function automatic t_box box_grow(input t_box bx, input t_count n, input t_coord x,
                                      input t_coord y);
        if (n == '0) begin
            bx.left   = x;
            bx.right  = x;
            bx.top    = y;
            bx.bottom = y;
        end else begin
            if (x < bx.left) bx.left = x;
            if (x > bx.right) bx.right = x;
            if (y < bx.top) bx.top = y;
            if (y > bx.bottom) bx.bottom = y;
        end
        return bx;
    endfunction

    function automatic t_count count_up(input t_count n);
        return (n == COUNT_MAX) ? n : n + 1'b1;
    endfunction

    function t_out_item predict_pixel_summary(input t_in_item px);
        t_out_item   res;
        logic [31:0] wsum;
        t_pix        lum;
        t_pix        step;
        t_coord      left_col;
        wsum = 32'd19595 * px.red + 32'd38470 * px.green + 32'd7471 * px.blue;
        lum  = wsum[23:16];
        if (color_match(sel_reg, px)) begin
            color_bbox = box_grow(color_bbox, color_hits, px.col, px.row);
            color_hits = count_up(color_hits);
        end
        // the previous pixel stands in as the left neighbor
        if (last_luma_ok && px.col != '0) begin
            left_col = px.col - 1'b1;
            step = (lum > last_luma) ? lum - last_luma : last_luma - lum;
            if (step > thr_reg && left_col >= EDGE_COL_LO && left_col <= EDGE_COL_HI &&
                px.row >= EDGE_ROW_LO && px.row <= EDGE_ROW_HI) begin
                edge_bbox = box_grow(edge_bbox, edge_hits, left_col, px.row);
                edge_hits = count_up(edge_hits);
            end
        end
        last_luma    = lum;
        last_luma_ok = 1'b1;
        res      = '0;
        res.gray = lum;
        if (px.last_pixel) begin
            res.frame_done   = 1'b1;
            res.edge_left    = edge_bbox.left;
            res.edge_right   = edge_bbox.right;
            res.edge_top     = edge_bbox.top;
            res.edge_bottom  = edge_bbox.bottom;
            res.color_left   = color_bbox.left;
            res.color_right  = color_bbox.right;
            res.color_top    = color_bbox.top;
            res.color_bottom = color_bbox.bottom;
            res.edge_count   = edge_hits;
            res.color_count  = color_hits;
            last_luma    = '0;
            last_luma_ok = 1'b0;
            edge_bbox    = '0;
            color_bbox   = '0;
            edge_hits    = '0;
            color_hits   = '0;
        end
        return res;
    endfunction

    function automatic string show_result(input t_out_item res);
        return {$sformatf("gray=%0d done=%0d edge=[%0d %0d %0d %0d] n=%0d",
                          res.gray, res.frame_done, res.edge_left, res.edge_right,
                          res.edge_top, res.edge_bottom, res.edge_count),
                $sformatf(" color=[%0d %0d %0d %0d] n=%0d", res.color_left,
                          res.color_right, res.color_top, res.color_bottom,
                          res.color_count)};
    endfunction

    // color near the bands of a product, straddling their limits
    function automatic t_in_item tint(input logic [SEL_BITS-1:0] sel);
        t_in_item px;
        px = '0;
        case (sel)
            PROD_ONE: begin
                px.red   = t_pix'($urandom_range(69, 176));
                px.green = t_pix'($urandom_range(0, 101));
                px.blue  = t_pix'($urandom_range(0, 51));
            end
            PROD_TWO: begin
                px.red   = t_pix'($urandom_range(0, 1));
                px.green = t_pix'($urandom_range(88, 255));
                px.blue  = t_pix'($urandom_range(0, 1));
            end
            PROD_THREE: begin
                if ($urandom_range(0, 1) == 0) begin
                    px.red   = t_pix'($urandom_range(99, 125));
                    px.green = t_pix'($urandom_range(40, 90));
                    px.blue  = t_pix'($urandom_range(10, 100));
                end else begin
                    px.red   = t_pix'($urandom_range(69, 100));
                    px.green = t_pix'($urandom_range(10, 50));
                    px.blue  = t_pix'($urandom_range(0, 10));
                end
            end
            PROD_FOUR: begin
                px.red   = ($urandom_range(0, 3) == 0) ? 8'd1 : 8'd0;
                px.green = ($urandom_range(0, 3) == 0) ? 8'd1 : 8'd0;
                px.blue  = ($urandom_range(0, 3) == 0) ? 8'd1 : 8'd0;
            end
            PROD_FIVE: begin
                px.red   = t_pix'($urandom_range(0, 101));
                px.green = t_pix'($urandom_range(0, 101));
                px.blue  = t_pix'($urandom_range(148, 255));
            end
            default: begin
                px.red   = t_pix'($urandom_range(0, 255));
                px.green = t_pix'($urandom_range(0, 255));
                px.blue  = t_pix'($urandom_range(0, 255));
            end
        endcase
        return px;
    endfunction

    task automatic add_item(input t_in_item px);
        pending_px.push_back(px);
        n_queued++;
    endtask

    task automatic add_px(input t_pix r, input t_pix g, input t_pix b, input t_coord c,
                          input t_coord rw, input logic last);
        t_in_item px;
        px.red        = r;
        px.green      = g;
        px.blue       = b;
        px.col        = c;
        px.row        = rw;
        px.last_pixel = last;
        add_item(px);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (n_accepted != n_queued || due_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [7:0] val);
        int seen0;
        @(negedge i_clk);
        seen0 = cfg_seen;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk);
        while (cfg_seen == seen0);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic start_phase(input logic [SEL_BITS-1:0] sel, input t_pix thr);
        logic [7:0] d;
        wait_drained();
        // junk in the unused select bits
        d = t_pix'($urandom_range(0, 255));
        d[SEL_BITS-1:0] = sel;
        write_reg(CFG_PRODUCT_SELECT, d);
        write_reg(CFG_EDGE_THRESHOLD, thr);
        @(posedge i_clk);
    endtask

    // mostly short raster patches ending in a frame end, some loose pixels
    task automatic gen_items(input int target, input logic [SEL_BITS-1:0] sel);
        int       done, r0, c0, w, h, rr, cc;
        t_in_item px, prev;
        done = 0;
        prev = '0;
        while (done < target) begin
            if ($urandom_range(0, 9) == 0) begin
                px = tint(SEL_SPARE_7);
                px.col        = t_coord'($urandom_range(0, 1023));
                px.row        = t_coord'($urandom_range(0, 1023));
                px.last_pixel = ($urandom_range(0, 3) == 0);
                add_item(px);
                prev = px;
                done++;
            end else begin
                r0 = $urandom_range(40, 470);
                c0 = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(190, 480);
                w  = $urandom_range(2, 20);
                h  = $urandom_range(1, 3);
                for (rr = 0; rr < h; rr++) begin
                    for (cc = 0; cc < w; cc++) begin
                        case ($urandom_range(0, 3))
                            0: px = tint(SEL_SPARE_7);
                            3: px = prev;
                            default: px = tint(sel);
                        endcase
                        px.col        = t_coord'(c0 + cc);
                        px.row        = t_coord'(r0 + rr);
                        px.last_pixel = (rr == h - 1 && cc == w - 1);
                        add_item(px);
                        prev = px;
                        done++;
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : watch_ports
        t_out_item want;
        px_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (px_taken) begin
            due_results.push_back(predict_pixel_summary(i_in_data));
            n_accepted++;
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PRODUCT_SELECT: sel_reg = i_cfg_data[SEL_BITS-1:0];
                CFG_EDGE_THRESHOLD: thr_reg = i_cfg_data;
                default: ;
            endcase
            cfg_seen++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: unexpected result %s", $time, show_result(o_out_data));
            end else begin
                want = due_results.pop_front();
                if (o_out_data.gray !== want.gray ||
                    o_out_data.frame_done !== want.frame_done ||
                    o_out_data.edge_left !== want.edge_left ||
                    o_out_data.edge_right !== want.edge_right ||
                    o_out_data.edge_top !== want.edge_top ||
                    o_out_data.edge_bottom !== want.edge_bottom ||
                    o_out_data.color_left !== want.color_left ||
                    o_out_data.color_right !== want.color_right ||
                    o_out_data.color_top !== want.color_top ||
                    o_out_data.color_bottom !== want.color_bottom ||
                    o_out_data.edge_count !== want.edge_count ||
                    o_out_data.color_count !== want.color_count) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("%0t: result mismatch", $time);
                        $display("  expected %s", show_result(want));
                        $display("  actual   %s", show_result(o_out_data));
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin : feed_pixels
        if (!i_in_valid || px_taken) begin
            if (gap_left != 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_px.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                gap_left   <= $urandom_range(0, 14);
                i_in_valid <= 1'b0;
            end else begin
                i_in_data  <= pending_px.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin : pace_results
        if (rx_hold) begin
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(0, 14);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin : run_test
        int       ph;
        t_pix     thr;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: window corners, column zero, neighbor just outside, max coords
        @(posedge i_clk);
        add_px(8'd0, 8'd0, 8'd0, 10'd0, 10'd0, 1'b0);
        add_px(8'd255, 8'd255, 8'd255, 10'd201, 10'd50, 1'b0);
        add_px(8'd255, 8'd0, 8'd0, 10'd470, 10'd459, 1'b0);
        add_px(8'd0, 8'd0, 8'd255, 10'd471, 10'd459, 1'b0);
        add_px(8'd255, 8'd255, 8'd255, 10'd0, 10'd100, 1'b0);
        add_px(8'd255, 8'd255, 8'd255, 10'd1023, 10'd1023, 1'b1);
        // lone pixel: both sets empty, no left neighbor
        add_px(8'd0, 8'd0, 8'd0, 10'd300, 10'd300, 1'b1);

        // one hit and one miss per product
        start_phase(PROD_ONE, THRESHOLD_RESET);
        add_px(8'd100, 8'd50, 8'd20, 10'd300, 10'd400, 1'b0);
        add_px(8'd155, 8'd205, 8'd235, 10'd301, 10'd400, 1'b1);
        start_phase(PROD_TWO, THRESHOLD_RESET);
        add_px(8'd0, 8'd200, 8'd0, 10'd300, 10'd100, 1'b0);
        add_px(8'd255, 8'd55, 8'd255, 10'd301, 10'd100, 1'b1);
        start_phase(PROD_THREE, THRESHOLD_RESET);
        add_px(8'd80, 8'd20, 8'd5, 10'd201, 10'd71, 1'b0);
        add_px(8'd175, 8'd235, 8'd250, 10'd202, 10'd71, 1'b1);
        start_phase(PROD_FOUR, THRESHOLD_RESET);
        add_px(8'd0, 8'd0, 8'd0, 10'd469, 10'd199, 1'b0);
        add_px(8'd255, 8'd255, 8'd255, 10'd468, 10'd199, 1'b1);
        start_phase(PROD_FIVE, THRESHOLD_RESET);
        add_px(8'd50, 8'd50, 8'd200, 10'd251, 10'd361, 1'b0);
        add_px(8'd205, 8'd205, 8'd55, 10'd252, 10'd361, 1'b1);

        for (ph = 0; ph < 9; ph++) begin
            if (ph == 1) thr = 8'd0;
            else if (ph == 2) thr = 8'd255;
            else if (ph % 3 == 0) thr = THRESHOLD_RESET;
            else thr = t_pix'($urandom_range(1, 80));
            start_phase(SEL_BITS'(ph % 8), thr);
            if (ph == 4) begin
                write_reg(CFG_SPARE_A, t_pix'($urandom_range(0, 255)));
                write_reg(CFG_SPARE_B, t_pix'($urandom_range(0, 255)));
                @(posedge i_clk);
            end
            if (ph == 2) begin
                // receiver holds off while items keep coming
                rx_hold <= 1'b1;
                gen_items(PHASE_ITEMS, SEL_BITS'(ph % 8));
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end else begin
                gen_items(PHASE_ITEMS, SEL_BITS'(ph % 8));
            end
        end

        // last stretch runs with no idling on either side
        idle_on <= 1'b0;
        start_phase(SEL_BITS'($urandom_range(0, 7)), t_pix'($urandom_range(0, 40)));
        gen_items(120, sel_reg);

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (n_bad == 0 && due_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin : watchdog
        #25_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
src/plceb_pkg.sv
src/plceb_luma.sv
src/plceb_color_match.sv
src/plceb_box_accum.sv
src/pixel_luma_color_edge_boxer_unit.sv
tb/sv/tb_pixel_luma_color_edge_boxer_unit.sv
